>>> src/glyph_tile_renderer_defines.svh
// Assertion macros for the glyph tile renderer.
`ifndef GLYPH_TILE_RENDERER_DEFINES_SVH
`define GLYPH_TILE_RENDERER_DEFINES_SVH

// Antecedent implies consequent in the same cycle.
`define GLR_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Condition never holds.
`define GLR_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

>>> src/glr_pkg.sv
// Shared types, constants and arithmetic helpers of the glyph tile renderer.
package glr_pkg;

  localparam int GLR_TILE_W      = 8;
  localparam int GLR_TILE_H      = 8;
  localparam int GLR_GLYPH_COUNT = 256;

  localparam int STORE_AW_MAX = 16;
  localparam int COORD_W      = 13;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 13;
  localparam int QUEUE_DEPTH  = 2;

  localparam logic [CFG_DATA_W-1:0] OUT_WIDTH_RST  = 13'd640;
  localparam logic [CFG_DATA_W-1:0] OUT_HEIGHT_RST = 13'd480;

  localparam logic [CFG_IDX_W-1:0] REG_OUT_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_HEIGHT = 2'd1;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_DRAW  = 1'b1;

  localparam logic [7:0] KEY_HI   = 8'd250;
  localparam logic [7:0] KEY_LO   = 8'd5;
  localparam logic [7:0] ALPHA_FF = 8'd255;

  typedef enum logic {CMD_WRITE, CMD_DRAW} cmd_op_t;

  typedef enum logic {SEQ_IDLE, SEQ_RUN} seq_state_t;

  typedef struct packed {
    cmd_op_t                 op;
    logic                    glyph_ok;
    logic [STORE_AW_MAX-1:0] addr;
    logic [COORD_W-1:0]      x0;
    logic [COORD_W-1:0]      y0;
    logic [23:0]             fg;
    logic [31:0]             bg;
    logic [31:0]             texel;
  } cmd_t;

  typedef struct packed {
    logic [11:0] x;
    logic [11:0] y;
    logic        visible;
    logic        last;
    logic        glyph_ok;
    logic [23:0] fg;
    logic [31:0] bg;
  } pix_t;

  // floor(v / 255) for v up to 255*255
  function automatic logic [7:0] div255(input logic [16:0] v);
    logic [16:0] t;
    t = v + {8'd0, v[16:8]} + 17'd1;
    return t[15:8];
  endfunction

endpackage

>>> src/glyph_tile_renderer.sv
// Top level of the glyph tile renderer: registers, front end, queue, sequencer, colour pipeline.
//
// A write item (op 0) loads one texel of the glyph store once it reaches
// the sequencer; out-of-range writes are accepted and dropped. A draw item (op 1) emits
// TILE_W*TILE_H pixels in row-major order from the glyph store, one per cycle while the output
// does not stall, and the first pixel passes the sequencer's pixel register and the colour
// pipeline stages before it appears. A two-entry command queue lets the input
// keep taking items while a draw is being walked. The glyph store has no clearing pass;
// texels read before they are written are undefined. out_width/out_height reset to 640/480
// and should be written only while the block is idle.
`include "glyph_tile_renderer_defines.svh"

module glyph_tile_renderer import glr_pkg::*; #(
  parameter int TILE_W      = GLR_TILE_W,
  parameter int TILE_H      = GLR_TILE_H,
  parameter int GLYPH_COUNT = GLR_GLYPH_COUNT
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_op,
  input  logic [7:0]            in_glyph,
  input  logic [8:0]            in_cell_col,
  input  logic [8:0]            in_cell_row,
  input  logic [23:0]           in_fg_rgb,
  input  logic [31:0]           in_bg_rgba,
  input  logic [2:0]            in_texel_x,
  input  logic [2:0]            in_texel_y,
  input  logic [31:0]           in_texel_rgba,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [11:0]           out_pixel_x,
  output logic [11:0]           out_pixel_y,
  output logic                  out_in_bounds,
  output logic [31:0]           out_color_rgba,
  output logic                  out_last
);

  logic [CFG_DATA_W-1:0] out_width_r;
  logic [CFG_DATA_W-1:0] out_height_r;

  logic        push;
  logic        q_ready;
  cmd_t        push_cmd;
  logic        q_valid;
  logic        q_pop;
  cmd_t        q_cmd;
  logic        adv;
  logic        pix_valid;
  pix_t        pix;
  logic [31:0] texel;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_width_r  <= OUT_WIDTH_RST;
      out_height_r <= OUT_HEIGHT_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_OUT_WIDTH:  out_width_r  <= cfg_data;
        REG_OUT_HEIGHT: out_height_r <= cfg_data;
        default: ;
      endcase
    end
  end

  glr_front #(
    .TILE_W      (TILE_W),
    .TILE_H      (TILE_H),
    .GLYPH_COUNT (GLYPH_COUNT)
  ) u_front (
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_op         (in_op),
    .in_glyph      (in_glyph),
    .in_cell_col   (in_cell_col),
    .in_cell_row   (in_cell_row),
    .in_fg_rgb     (in_fg_rgb),
    .in_bg_rgba    (in_bg_rgba),
    .in_texel_x    (in_texel_x),
    .in_texel_y    (in_texel_y),
    .in_texel_rgba (in_texel_rgba),
    .push          (push),
    .q_ready       (q_ready),
    .cmd           (push_cmd)
  );

  glr_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_ready (q_ready),
    .push_cmd   (push_cmd),
    .pop_valid  (q_valid),
    .pop        (q_pop),
    .pop_cmd    (q_cmd)
  );

  glr_back #(
    .TILE_W      (TILE_W),
    .TILE_H      (TILE_H),
    .GLYPH_COUNT (GLYPH_COUNT)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_pop      (q_pop),
    .q_cmd      (q_cmd),
    .out_width  (out_width_r),
    .out_height (out_height_r),
    .adv        (adv),
    .pix_valid  (pix_valid),
    .pix        (pix),
    .texel      (texel)
  );

  glr_shade u_shade (
    .clk            (clk),
    .rst_n          (rst_n),
    .pix_valid      (pix_valid),
    .pix            (pix),
    .texel          (texel),
    .adv            (adv),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_pixel_x    (out_pixel_x),
    .out_pixel_y    (out_pixel_y),
    .out_in_bounds  (out_in_bounds),
    .out_color_rgba (out_color_rgba),
    .out_last       (out_last)
  );

  `GLR_ASSERT_NEVER(a_pop_empty, q_pop && !q_valid, "queue popped while empty")
  `GLR_ASSERT_IMPL(a_clip_black, out_valid && !out_in_bounds, out_color_rgba == 32'd0, "clipped pixel not zero")

endmodule

>>> src/glr_front.sv
// Front end: takes items, drops bad texel writes, builds store addresses and origins.
module glr_front import glr_pkg::*; #(
  parameter int TILE_W      = GLR_TILE_W,
  parameter int TILE_H      = GLR_TILE_H,
  parameter int GLYPH_COUNT = GLR_GLYPH_COUNT
) (
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_op,
  input  logic [7:0]  in_glyph,
  input  logic [8:0]  in_cell_col,
  input  logic [8:0]  in_cell_row,
  input  logic [23:0] in_fg_rgb,
  input  logic [31:0] in_bg_rgba,
  input  logic [2:0]  in_texel_x,
  input  logic [2:0]  in_texel_y,
  input  logic [31:0] in_texel_rgba,
  output logic        push,
  input  logic        q_ready,
  output cmd_t        cmd
);

  localparam int DEPTH = GLYPH_COUNT * TILE_W * TILE_H;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic          glyph_ok;
  logic          texel_ok;
  logic [AW-1:0] waddr;
  logic [AW-1:0] baddr;

  assign glyph_ok = {1'b0, in_glyph} < 9'(GLYPH_COUNT);
  assign texel_ok = (5'(in_texel_x) < 5'(TILE_W)) && (5'(in_texel_y) < 5'(TILE_H));

  assign waddr = AW'((int'(in_glyph) * TILE_H + int'(in_texel_y)) * TILE_W + int'(in_texel_x));
  assign baddr = glyph_ok ? AW'(int'(in_glyph) * TILE_H * TILE_W) : '0;

  assign in_ready = q_ready;
  assign push     = in_valid && q_ready && (in_op == OP_DRAW || (glyph_ok && texel_ok));

  always_comb begin
    cmd.op       = (in_op == OP_DRAW) ? CMD_DRAW : CMD_WRITE;
    cmd.glyph_ok = glyph_ok;
    cmd.addr     = STORE_AW_MAX'((in_op == OP_DRAW) ? baddr : waddr);
    cmd.x0       = COORD_W'(int'(in_cell_col) * TILE_W);
    cmd.y0       = COORD_W'(int'(in_cell_row) * TILE_H);
    cmd.fg       = in_fg_rgb;
    cmd.bg       = in_bg_rgba;
    cmd.texel    = in_texel_rgba;
  end

endmodule

>>> src/glr_queue.sv
// Short command queue between the front end and the pixel sequencer.
module glr_queue import glr_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  output logic push_ready,
  input  cmd_t push_cmd,
  output logic pop_valid,
  input  logic pop,
  output cmd_t pop_cmd
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  cmd_t          slot_r [DEPTH];
  logic [PW-1:0] wp_r;
  logic [PW-1:0] rp_r;
  logic [CW-1:0] cnt_r;

  assign push_ready = cnt_r != CW'(DEPTH);
  assign pop_valid  = cnt_r != '0;
  assign pop_cmd    = slot_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wp_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= (wp_r == PW'(DEPTH - 1)) ? '0 : wp_r + 1'b1;
      end
      if (pop) begin
        rp_r <= (rp_r == PW'(DEPTH - 1)) ? '0 : rp_r + 1'b1;
      end
      cnt_r <= cnt_r + CW'(push) - CW'(pop);
    end
  end

endmodule

>>> src/glr_back.sv
// Pixel sequencer: glyph store, texel writes, row-major tile walk and clipping.
module glr_back import glr_pkg::*; #(
  parameter int TILE_W      = GLR_TILE_W,
  parameter int TILE_H      = GLR_TILE_H,
  parameter int GLYPH_COUNT = GLR_GLYPH_COUNT
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  q_valid,
  output logic                  q_pop,
  input  cmd_t                  q_cmd,
  input  logic [CFG_DATA_W-1:0] out_width,
  input  logic [CFG_DATA_W-1:0] out_height,
  input  logic                  adv,
  output logic                  pix_valid,
  output pix_t                  pix,
  output logic [31:0]           texel
);

  localparam int DEPTH = GLYPH_COUNT * TILE_W * TILE_H;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int XW    = (TILE_W > 1) ? $clog2(TILE_W) : 1;
  localparam int YW    = (TILE_H > 1) ? $clog2(TILE_H) : 1;

  logic [31:0]        mem [DEPTH];

  seq_state_t         state_r;
  seq_state_t         state_nxt;
  logic               mem_we;
  logic               issue;
  logic               row_end;
  logic               tile_end;

  logic [AW-1:0]      addr_r;
  logic [XW-1:0]      px_r;
  logic [YW-1:0]      py_r;
  logic [COORD_W-1:0] x0_r;
  logic [COORD_W-1:0] y0_r;
  logic [23:0]        fg_r;
  logic [31:0]        bg_r;
  logic               ok_r;

  logic [COORD_W-1:0] x;
  logic [COORD_W-1:0] y;

  logic               pix_valid_r;
  pix_t               pix_r;
  logic [31:0]        texel_r;

  assign row_end  = px_r == XW'(TILE_W - 1);
  assign tile_end = row_end && (py_r == YW'(TILE_H - 1));
  assign x        = x0_r + COORD_W'(px_r);
  assign y        = y0_r + COORD_W'(py_r);

  always_comb begin
    state_nxt = state_r;
    q_pop     = 1'b0;
    mem_we    = 1'b0;
    issue     = 1'b0;
    unique case (state_r)
      SEQ_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          if (q_cmd.op == CMD_DRAW) begin
            state_nxt = SEQ_RUN;
          end else begin
            mem_we = 1'b1;
          end
        end
      end
      SEQ_RUN: begin
        if (adv) begin
          issue = 1'b1;
          if (tile_end) begin
            state_nxt = SEQ_IDLE;
          end
        end
      end
      default: state_nxt = SEQ_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= SEQ_IDLE;
      pix_valid_r <= 1'b0;
      px_r        <= '0;
      py_r        <= '0;
    end else begin
      state_r <= state_nxt;
      if (adv) begin
        pix_valid_r <= issue;
      end
      if (q_pop && q_cmd.op == CMD_DRAW) begin
        px_r <= '0;
        py_r <= '0;
      end else if (issue) begin
        if (row_end) begin
          px_r <= '0;
          py_r <= py_r + 1'b1;
        end else begin
          px_r <= px_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && q_cmd.op == CMD_DRAW) begin
      addr_r <= q_cmd.addr[AW-1:0];
      x0_r   <= q_cmd.x0;
      y0_r   <= q_cmd.y0;
      fg_r   <= q_cmd.fg;
      bg_r   <= q_cmd.bg;
      ok_r   <= q_cmd.glyph_ok;
    end else if (issue) begin
      addr_r <= addr_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[q_cmd.addr[AW-1:0]] <= q_cmd.texel;
    end
    if (adv) begin
      texel_r <= mem[addr_r];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pix_r.x        <= x[11:0];
      pix_r.y        <= y[11:0];
      pix_r.visible  <= (x < out_width) && (y < out_height);
      pix_r.last     <= tile_end;
      pix_r.glyph_ok <= ok_r;
      pix_r.fg       <= fg_r;
      pix_r.bg       <= bg_r;
    end
  end

  assign pix_valid = pix_valid_r;
  assign pix       = pix_r;
  assign texel     = texel_r;

endmodule

>>> src/glr_shade.sv
// Colour pipeline: colour key, foreground modulation, alpha blend, output register.
module glr_shade import glr_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        pix_valid,
  input  pix_t        pix,
  input  logic [31:0] texel,
  output logic        adv,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [11:0] out_pixel_x,
  output logic [11:0] out_pixel_y,
  output logic        out_in_bounds,
  output logic [31:0] out_color_rgba,
  output logic        out_last
);

  logic [31:0] tex;
  logic        key;

  logic        v2_r;
  pix_t        p2_r;
  logic        key2_r;
  logic [7:0]  a2_r;
  logic [15:0] prod_r [3];

  logic        v3_r;
  pix_t        p3_r;
  logic        key3_r;
  logic [7:0]  a3_r;
  logic [7:0]  m_r  [3];
  logic [15:0] ta_r [3];
  logic [15:0] tb_r [3];

  logic [7:0]  m_nxt [3];
  logic [7:0]  ia;
  logic [31:0] color_nxt;
  logic [7:0]  blend [3];

  logic        out_valid_r;
  logic [11:0] x_r;
  logic [11:0] y_r;
  logic        inb_r;
  logic [31:0] color_r;
  logic        last_r;

  assign adv = !out_valid_r || out_ready;
  assign tex = pix.glyph_ok ? texel : 32'd0;
  assign key = (tex[31:24] > KEY_HI) && (tex[23:16] < KEY_LO) && (tex[15:8] > KEY_HI);
  assign ia  = ALPHA_FF - a2_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      m_nxt[i] = div255({1'b0, prod_r[i]});
      blend[i] = div255(17'(ta_r[i]) + 17'(tb_r[i]));
    end
    if (!p3_r.visible) begin
      color_nxt = 32'd0;
    end else if (key3_r || a3_r == 8'd0) begin
      color_nxt = p3_r.bg;
    end else if (a3_r == ALPHA_FF) begin
      color_nxt = {m_r[0], m_r[1], m_r[2], ALPHA_FF};
    end else begin
      color_nxt = {blend[0], blend[1], blend[2], ALPHA_FF};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      v2_r        <= pix_valid;
      v3_r        <= v2_r;
      out_valid_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p2_r   <= pix;
      key2_r <= key;
      a2_r   <= tex[7:0];
      for (int i = 0; i < 3; i++) begin
        prod_r[i] <= tex[31-8*i -: 8] * pix.fg[23-8*i -: 8];
      end
      p3_r   <= p2_r;
      key3_r <= key2_r;
      a3_r   <= a2_r;
      for (int i = 0; i < 3; i++) begin
        m_r[i]  <= m_nxt[i];
        ta_r[i] <= m_nxt[i] * a2_r;
        tb_r[i] <= p2_r.bg[31-8*i -: 8] * ia;
      end
      x_r     <= p3_r.x;
      y_r     <= p3_r.y;
      inb_r   <= p3_r.visible;
      color_r <= color_nxt;
      last_r  <= p3_r.last;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_pixel_x    = x_r;
  assign out_pixel_y    = y_r;
  assign out_in_bounds  = inb_r;
  assign out_color_rgba = color_r;
  assign out_last       = last_r;

endmodule

>>> dv/tb.sv
// Testbench for glyph_tile_renderer: directed and random items, pixels checked against a predictor.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import glr_pkg::*;

  localparam int TW           = GLR_TILE_W;
  localparam int TH           = GLR_TILE_H;
  localparam int TILE_PX      = TW * TH;
  localparam int GLYPHS       = GLR_GLYPH_COUNT;
  localparam int CLK_HALF     = 6;
  localparam int GAP_MAX      = 17;
  localparam int DRAIN_CYCLES = 32;
  localparam int MIX_ITEMS    = 19;
  localparam int LIMIT_CYCLES = 1_000_000;

  // indexes past the two real registers
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

  typedef struct packed {
    logic        op;
    logic [7:0]  glyph;
    logic [8:0]  col;
    logic [8:0]  row;
    logic [23:0] fg;
    logic [31:0] bg;
    logic [2:0]  tx;
    logic [2:0]  ty;
    logic [31:0] texel;
  } glyph_cmd_t;

  typedef struct packed {
    logic [11:0] x;
    logic [11:0] y;
    logic        inb;
    logic [31:0] color;
    logic        last;
  } tile_px_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  in_valid;
  logic                  in_ready;
  logic                  in_op;
  logic [7:0]            in_glyph;
  logic [8:0]            in_cell_col;
  logic [8:0]            in_cell_row;
  logic [23:0]           in_fg_rgb;
  logic [31:0]           in_bg_rgba;
  logic [2:0]            in_texel_x;
  logic [2:0]            in_texel_y;
  logic [31:0]           in_texel_rgba;
  logic                  out_valid;
  logic                  out_ready;
  logic [11:0]           out_pixel_x;
  logic [11:0]           out_pixel_y;
  logic                  out_in_bounds;
  logic [31:0]           out_color_rgba;
  logic                  out_last;

  tile_px_t    pending_px[$];
  logic [31:0] texel_mem [GLYPHS*TILE_PX];
  bit          texel_set [GLYPHS*TILE_PX];
  int unsigned set_count [GLYPHS];
  logic [7:0]  drawable[$];
  logic [12:0] width_reg;
  logic [12:0] height_reg;
  int          errors;
  int          draws_sent;
  int          writes_sent;
  int          px_checked;
  int          reg_writes;
  bit          src_quiet;
  bit          snk_quiet;

  glyph_tile_renderer dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_op         (in_op),
    .in_glyph      (in_glyph),
    .in_cell_col   (in_cell_col),
    .in_cell_row   (in_cell_row),
    .in_fg_rgb     (in_fg_rgb),
    .in_bg_rgba    (in_bg_rgba),
    .in_texel_x    (in_texel_x),
    .in_texel_y    (in_texel_y),
    .in_texel_rgba (in_texel_rgba),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_pixel_x   (out_pixel_x),
    .out_pixel_y   (out_pixel_y),
    .out_in_bounds (out_in_bounds),
    .out_color_rgba(out_color_rgba),
    .out_last      (out_last)
  );

  always begin
    clk = 1'b0;
    #(CLK_HALF);
    clk = 1'b1;
    #(CLK_HALF);
  end

  function automatic int unsigned idle_gap(input bit quiet);
    return quiet ? 0 : $urandom_range(0, GAP_MAX);
  endfunction

  // colour key, modulate by foreground, then blend over background
  function automatic logic [31:0] blend_texel(input logic [31:0] tex, input logic [23:0] fg,
                                              input logic [31:0] bg);
    int unsigned tr, tg, tb, ta, mr, mg, mb, ia, ro, go, bo;
    tr = tex[31:24];
    tg = tex[23:16];
    tb = tex[15:8];
    ta = tex[7:0];
    if (tr > KEY_HI && tg < KEY_LO && tb > KEY_HI) return bg;
    mr = tr * fg[23:16] / 255;
    mg = tg * fg[15:8] / 255;
    mb = tb * fg[7:0] / 255;
    if (ta == ALPHA_FF) return {mr[7:0], mg[7:0], mb[7:0], ALPHA_FF};
    if (ta == 0) return bg;
    ia = 255 - ta;
    ro = (mr * ta + bg[31:24] * ia) / 255;
    go = (mg * ta + bg[23:16] * ia) / 255;
    bo = (mb * ta + bg[15:8] * ia) / 255;
    return {ro[7:0], go[7:0], bo[7:0], ALPHA_FF};
  endfunction

  function automatic logic [31:0] pick_texel();
    logic [31:0] t;
    t = $urandom;
    case ($urandom_range(0, 7))
      0: t[31:8] = {8'($urandom_range(251, 255)), 8'($urandom_range(0, 4)),
                    8'($urandom_range(251, 255))};
      1: t[7:0] = 8'h00;
      2: t[7:0] = 8'hFF;
      3: t[7:0] = ($urandom_range(0, 1) != 0) ? 8'h01 : 8'hFE;
      default: ;
    endcase
    return t;
  endfunction

  function automatic logic [31:0] pick_colour();
    case ($urandom_range(0, 5))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] corner_texel(input int i);
    case (i)
      0:  return 32'hFB04FB80;  // just inside the key
      1:  return 32'hFF00FF00;
      2:  return 32'hFA04FB80;  // red one short of the key
      3:  return 32'hFB05FB80;  // green one past
      4:  return 32'hFB04FA80;  // blue one short
      5:  return 32'hFFFFFFFF;
      6:  return 32'h00000000;
      7:  return 32'hFF00FFFF;  // key wins over opaque alpha
      8:  return 32'hFFFFFF01;
      9:  return 32'hFFFFFFFE;
      10: return 32'h80C040FF;
      11: return 32'h0000007F;
      default: return pick_texel();
    endcase
  endfunction

  function automatic glyph_cmd_t write_cmd(input logic [7:0] g, input logic [2:0] tx,
                                           input logic [2:0] ty, input logic [31:0] texel);
    glyph_cmd_t c;
    c.op    = OP_WRITE;
    c.glyph = g;
    c.col   = 9'($urandom);
    c.row   = 9'($urandom);
    c.fg    = 24'($urandom);
    c.bg    = $urandom;
    c.tx    = tx;
    c.ty    = ty;
    c.texel = texel;
    return c;
  endfunction

  function automatic glyph_cmd_t draw_cmd(input logic [7:0] g, input logic [8:0] col,
                                          input logic [8:0] row, input logic [23:0] fg,
                                          input logic [31:0] bg);
    glyph_cmd_t c;
    c.op    = OP_DRAW;
    c.glyph = g;
    c.col   = col;
    c.row   = row;
    c.fg    = fg;
    c.bg    = bg;
    c.tx    = 3'($urandom);
    c.ty    = 3'($urandom);
    c.texel = $urandom;
    return c;
  endfunction

  // cell index near the clip edge half the time
  function automatic logic [8:0] edge_cell(input int unsigned limit, input int unsigned tile);
    int c;
    if ($urandom_range(0, 1) == 0) return 9'($urandom_range(0, 511));
    c = int'(limit / tile) + int'($urandom_range(0, 2)) - 1;
    if (c < 0) c = 0;
    if (c > 511) c = 511;
    return 9'(c);
  endfunction

  task automatic predict_item(input glyph_cmd_t c);
    int unsigned base, x, y;
    tile_px_t    p;
    base = c.glyph * TILE_PX;
    if (c.op == OP_WRITE) begin
      writes_sent++;
      texel_mem[base + c.ty * TW + c.tx] = c.texel;
      if (!texel_set[base + c.ty * TW + c.tx]) begin
        texel_set[base + c.ty * TW + c.tx] = 1'b1;
        set_count[c.glyph]++;
        if (set_count[c.glyph] == TILE_PX) drawable.push_back(c.glyph);
      end
    end else begin
      draws_sent++;
      for (int py = 0; py < TH; py++) begin
        for (int px = 0; px < TW; px++) begin
          x       = c.col * TW + px;
          y       = c.row * TH + py;
          p.x     = x[11:0];
          p.y     = y[11:0];
          p.inb   = (x < width_reg) && (y < height_reg);
          p.color = p.inb ? blend_texel(texel_mem[base + py * TW + px], c.fg, c.bg) : '0;
          p.last  = (py == TH - 1) && (px == TW - 1);
          pending_px.push_back(p);
        end
      end
    end
  endtask

  task automatic send_item(input glyph_cmd_t c);
    int unsigned gap;
    gap = idle_gap(src_quiet);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_op         <= c.op;
    in_glyph      <= c.glyph;
    in_cell_col   <= c.col;
    in_cell_row   <= c.row;
    in_fg_rgb     <= c.fg;
    in_bg_rgba    <= c.bg;
    in_texel_x    <= c.tx;
    in_texel_y    <= c.ty;
    in_texel_rgba <= c.texel;
    @(posedge clk);
    while (in_ready !== 1'b1) @(posedge clk);
    predict_item(c);
    @(negedge clk);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_px.size() != 0) @(negedge clk);
    // a trailing texel write may still be in flight
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data,
                           input bit more);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (cfg_ready !== 1'b1) @(posedge clk);
    reg_writes++;
    if (idx == REG_OUT_WIDTH) width_reg = data;
    else if (idx == REG_OUT_HEIGHT) height_reg = data;
    @(negedge clk);
    if (!more) cfg_valid <= 1'b0;
  endtask

  task automatic set_output_size(input logic [12:0] w, input logic [12:0] h);
    wait_idle();
    write_reg(REG_OUT_WIDTH, w, 1'b1);
    write_reg(REG_OUT_HEIGHT, h, 1'b0);
  endtask

  task automatic load_glyph(input logic [7:0] g);
    for (int i = 0; i < TILE_PX; i++)
      send_item(write_cmd(g, 3'(i % TW), 3'(i / TW), pick_texel()));
  endtask

  task automatic test_corner_glyph();
    for (int i = 0; i < TILE_PX; i++)
      send_item(write_cmd(8'h00, 3'(i % TW), 3'(i / TW), corner_texel(i)));
  endtask

  task automatic test_colour_extremes();
    send_item(draw_cmd(8'h00, 9'd0, 9'd0, 24'h000000, 32'h0000_0000));
    send_item(draw_cmd(8'h00, 9'd0, 9'd0, 24'hFFFFFF, 32'hFFFF_FFFF));
    send_item(draw_cmd(8'h00, 9'd1, 9'd2, 24'hFFFFFF, 32'h1234_5600));
    send_item(draw_cmd(8'h00, 9'd3, 9'd4, 24'($urandom), $urandom));
  endtask

  // texel write straight followed by a draw of the same glyph
  task automatic test_rewrite_then_draw();
    send_item(write_cmd(8'h00, 3'd3, 3'd5, 32'hFE02FE40));
    send_item(draw_cmd(8'h00, 9'd5, 9'd5, 24'hFF8000, 32'h0080_FF7F));
    send_item(write_cmd(8'h00, 3'd3, 3'd5, 32'h4080C0FF));
    send_item(draw_cmd(8'h00, 9'd5, 9'd5, 24'h00FF80, 32'hC0C0_C0C0));
  endtask

  task automatic test_clipping();
    // reset size first
    send_item(draw_cmd(8'h00, 9'd79, 9'd59, 24'hFFFFFF, 32'h1020_3040));
    send_item(draw_cmd(8'h00, 9'd80, 9'd0, 24'hFFFFFF, 32'h1020_3040));
    send_item(draw_cmd(8'h00, 9'd0, 9'd60, 24'hFFFFFF, 32'h1020_3040));
    set_output_size(13'd0, 13'd480);
    send_item(draw_cmd(8'h00, 9'd0, 9'd0, 24'($urandom), $urandom));
    set_output_size(13'd640, 13'd0);
    send_item(draw_cmd(8'h00, 9'd0, 9'd0, 24'($urandom), $urandom));
    set_output_size(13'd1, 13'd1);
    send_item(draw_cmd(8'h00, 9'd0, 9'd0, 24'($urandom), $urandom));
    set_output_size(13'd8191, 13'd8191);
    send_item(draw_cmd(8'h00, 9'd511, 9'd511, 24'($urandom), $urandom));
    set_output_size(13'd4095, 13'd4096);
    send_item(draw_cmd(8'h00, 9'd511, 9'd511, 24'($urandom), $urandom));
  endtask

  task automatic test_spare_regs();
    set_output_size(13'd100, 13'd60);
    write_reg(REG_SPARE_A, 13'h1FFF, 1'b1);
    write_reg(REG_SPARE_B, 13'h0000, 1'b0);
    send_item(draw_cmd(8'h00, 9'd12, 9'd7, 24'hFFFFFF, 32'hFFFF_FFFF));
  endtask

  task automatic mix_items(input int n);
    int unsigned kind;
    logic [7:0]  g;
    repeat (n) begin
      if ($urandom_range(0, 15) == 0) src_quiet = !src_quiet;
      if ($urandom_range(0, 15) == 0) snk_quiet = !snk_quiet;
      kind = $urandom_range(0, 9);
      g = drawable[$urandom_range(0, drawable.size() - 1)];
      if (kind < 6) begin
        send_item(draw_cmd(g, edge_cell(width_reg, TW), edge_cell(height_reg, TH),
                           24'(pick_colour()), pick_colour()));
      end else if (kind < 9) begin
        send_item(write_cmd(g, 3'($urandom), 3'($urandom), pick_texel()));
      end else begin
        send_item(write_cmd(8'($urandom), 3'($urandom), 3'($urandom), pick_texel()));
      end
    end
  endtask

  task automatic test_random();
    set_output_size(OUT_WIDTH_RST, OUT_HEIGHT_RST);
    load_glyph(8'hFF);
    mix_items(MIX_ITEMS);
    set_output_size(13'($urandom_range(1, 4096)), 13'($urandom_range(1, 4096)));
    mix_items(MIX_ITEMS);
    set_output_size(13'($urandom_range(0, 8191)), 13'($urandom_range(0, 8191)));
    mix_items(MIX_ITEMS);
    set_output_size(13'($urandom_range(1, 64)), 13'($urandom_range(1, 64)));
    mix_items(MIX_ITEMS);
  endtask

  // result side: random stall before each item unless snk_quiet is set
  initial begin : sink
    int unsigned hold;
    out_ready = 1'b0;
    @(negedge clk);
    forever begin
      hold = idle_gap(snk_quiet);
      if (hold != 0) begin
        out_ready <= 1'b0;
        repeat (hold) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (out_valid !== 1'b1);
      @(negedge clk);
    end
  end

  always @(posedge clk) begin : check_px
    tile_px_t want;
    if (rst_n && out_valid === 1'b1 && out_ready) begin
      if (pending_px.size() == 0) begin
        errors++;
        $error("unexpected pixel x=%0d y=%0d", out_pixel_x, out_pixel_y);
      end else begin
        want = pending_px.pop_front();
        px_checked++;
        if (out_pixel_x !== want.x) begin
          errors++;
          $error("pixel_x: expected %0d, got %0d", want.x, out_pixel_x);
        end
        if (out_pixel_y !== want.y) begin
          errors++;
          $error("pixel_y: expected %0d, got %0d", want.y, out_pixel_y);
        end
        if (out_in_bounds !== want.inb) begin
          errors++;
          $error("in_bounds: expected %0b, got %0b", want.inb, out_in_bounds);
        end
        if (out_color_rgba !== want.color) begin
          errors++;
          $error("color_rgba: expected %08h, got %08h", want.color, out_color_rgba);
        end
        if (out_last !== want.last) begin
          errors++;
          $error("last: expected %0b, got %0b", want.last, out_last);
        end
      end
    end
  end

  initial begin
    #(2 * CLK_HALF * LIMIT_CYCLES);
    $display("FAIL glyph_tile_renderer");
    $finish;
  end

  initial begin
    rst_n         = 1'b0;
    cfg_valid     = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    in_valid      = 1'b0;
    in_op         = OP_WRITE;
    in_glyph      = '0;
    in_cell_col   = '0;
    in_cell_row   = '0;
    in_fg_rgb     = '0;
    in_bg_rgba    = '0;
    in_texel_x    = '0;
    in_texel_y    = '0;
    in_texel_rgba = '0;
    width_reg     = OUT_WIDTH_RST;
    height_reg    = OUT_HEIGHT_RST;
    src_quiet     = 1'b0;
    snk_quiet     = 1'b0;
    errors        = 0;
    draws_sent    = 0;
    writes_sent   = 0;
    px_checked    = 0;
    reg_writes    = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_corner_glyph();
    test_colour_extremes();
    test_rewrite_then_draw();
    test_clipping();
    test_spare_regs();
    test_random();
    wait_idle();

    $display("Sent %0d draws and %0d texel writes over %0d register writes,",
             draws_sent, writes_sent, reg_writes);
    $display("compared %0d pixels including clipped, keyed and blended ones.", px_checked);
    if (errors == 0) begin
      $display("PASS glyph_tile_renderer");
    end else begin
      $display("FAIL glyph_tile_renderer");
    end
    $finish;
  end

endmodule
